### hdl/i2cbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_pkg
// Shared widths, command codes and item structs of the I2C byte engine.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TickW = 16;
  localparam int unsigned StepW = 5;

  localparam logic [CmdW-1:0] CMD_IDLE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_START = 3'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 3'd2;
  localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ  = 3'd4;

  localparam logic [TickW-1:0] HALF_PERIOD_RST = 16'd4;

  typedef struct packed {
    logic [CmdW-1:0]  req_type;
    logic [ByteW-1:0] write_data;
    logic             sda_in;
  } req_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic [ByteW-1:0] read_data;
    logic             read_valid;
  } res_t;

endpackage

### hdl/i2cbb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface i2cbb_req_if;
  import i2cbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  req_type;
  logic [ByteW-1:0] write_data;
  logic             sda_in;

  modport source (output valid, req_type, write_data, sda_in, input ready);
  modport sink   (input valid, req_type, write_data, sda_in, output ready);
endinterface

interface i2cbb_res_if;
  import i2cbb_pkg::*;
  logic             valid;
  logic             ready;
  logic             scl_out;
  logic             sda_out;
  logic             busy_res;
  logic [ByteW-1:0] read_data;
  logic             read_valid;

  modport source (output valid, scl_out, sda_out, busy_res, read_data, read_valid,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, read_data, read_valid,
                  output ready);
endinterface

interface i2cbb_cfg_if;
  import i2cbb_pkg::*;
  logic             valid;
  logic             ready;
  logic [TickW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hdl/i2c_bitbang_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bitbang_master_top
// I2C master byte engine: start, stop, write and read sequences on SCL/SDA
// levels, timed by tick items.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req_i   | in  | valid/ready | req_type, write_data, sda_in
//  res_o   | out | valid/ready | scl_out, sda_out, busy_res, read_data, read_valid
//  cfg_i   | in  | valid/ready | data = half_period_ticks (ready always high)
//
//  One item per cycle while res_o is not stalled; each item passes the input
//  register, then the sequencer step, then the result register.
//  Reset (async, low) idles the bus high and sets half_period_ticks to 4.
//  A stalled result holds its register; the input register then fills and
//  req_i.ready drops.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  i2cbb_req_if.sink   req_i,
  i2cbb_res_if.source res_o,
  i2cbb_cfg_if.sink   cfg_i
);
  import i2cbb_pkg::*;

  logic in_v_q;
  req_t in_q;
  logic out_v_q;
  res_t out_q;
  res_t step_res;
  logic adv;
  logic step;

  assign adv         = !out_v_q || res_o.ready;
  assign step        = in_v_q && adv;
  assign req_i.ready = !in_v_q || adv;
  assign cfg_i.ready = 1'b1;

  i2cbb_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .req_i      (in_q),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.data),
    .res_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_v_q <= req_i.valid;
      end
      if (adv) begin
        out_v_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q.req_type   <= req_i.req_type;
      in_q.write_data <= req_i.write_data;
      in_q.sda_in     <= req_i.sda_in;
    end
    if (step) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.scl_out    = out_q.scl_out;
  assign res_o.sda_out    = out_q.sda_out;
  assign res_o.busy_res   = out_q.busy_res;
  assign res_o.read_data  = out_q.read_data;
  assign res_o.read_valid = out_q.read_valid;

endmodule

### hdl/i2cbb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_seq
// Line sequencer state and one-item step logic: delay counting, bit phases,
// command start and read assembly. Emits the result of the stepped item.
// ----------------------------------------------------------------------------
module i2cbb_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  i2cbb_pkg::req_t              req_i,
  input  logic                         cfg_we_i,
  input  logic [i2cbb_pkg::TickW-1:0]  cfg_data_i,
  output i2cbb_pkg::res_t              res_o
);
  import i2cbb_pkg::*;

  logic [TickW-1:0] half_q;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [StepW-1:0] step_q, step_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [ByteW-1:0] last_q, last_d;
  logic             scl_q, scl_d;
  logic             sda_q, sda_d;
  logic             rvalid;
  logic [TickW-1:0] tick_inc;
  logic [3:0]       bit_pos;
  logic             second;
  logic [2:0]       wr_idx;

  assign tick_inc = tick_q + TickW'(1);
  assign bit_pos  = step_q[StepW-1:1];
  assign second   = step_q[0];
  assign wr_idx   = 3'(4'd6 - bit_pos);

  always_comb begin
    cmd_d   = cmd_q;
    step_d  = step_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    last_d  = last_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rvalid  = 1'b0;
    if (req_i.req_type == CMD_IDLE) begin
      if (cmd_q != CMD_IDLE) begin
        tick_d = tick_inc;
        if (tick_inc >= half_q) begin
          // one delay unit ended
          tick_d = '0;
          step_d = step_q + StepW'(1);
          unique case (cmd_q)
            CMD_START: begin
              if (step_q == '0) begin
                sda_d = 1'b0;
              end else begin
                scl_d = 1'b0;
                cmd_d = CMD_IDLE;
              end
            end
            CMD_STOP: begin
              if (step_q == '0) begin
                sda_d = 1'b1;
              end else begin
                cmd_d = CMD_IDLE;
              end
            end
            CMD_WRITE: begin
              if (!second) begin
                scl_d = 1'b1;
              end else begin
                scl_d = 1'b0;
                if (bit_pos < 4'd7) begin
                  sda_d = shift_q[wr_idx];
                end else begin
                  cmd_d = CMD_IDLE;
                end
              end
            end
            CMD_READ: begin
              if (bit_pos >= 4'd8) begin
                scl_d  = 1'b0;
                last_d = shift_q;
                cmd_d  = CMD_IDLE;
                rvalid = 1'b1;
              end else if (!second) begin
                shift_d = {shift_q[ByteW-2:0], req_i.sda_in};
                scl_d   = 1'b0;
              end else if (bit_pos < 4'd7) begin
                scl_d = 1'b1;
              end else begin
                sda_d = 1'b0;
                scl_d = 1'b1;
              end
            end
            default: begin
              cmd_d = CMD_IDLE;
            end
          endcase
          if (cmd_d == CMD_IDLE) begin
            step_d = '0;
          end
        end
      end
    end else if (req_i.req_type <= CMD_READ && cmd_q == CMD_IDLE) begin
      cmd_d  = req_i.req_type;
      step_d = '0;
      tick_d = '0;
      unique case (req_i.req_type)
        CMD_START: begin
          scl_d = 1'b1;
          sda_d = 1'b1;
        end
        CMD_STOP: begin
          scl_d = 1'b1;
          sda_d = 1'b0;
        end
        CMD_WRITE: begin
          shift_d = req_i.write_data;
          sda_d   = req_i.write_data[ByteW-1];
        end
        default: begin
          shift_d = '0;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HALF_PERIOD_RST;
      cmd_q   <= CMD_IDLE;
      step_q  <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      last_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_data_i;
      end
      if (step_i) begin
        cmd_q   <= cmd_d;
        step_q  <= step_d;
        tick_q  <= tick_d;
        shift_q <= shift_d;
        last_q  <= last_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
      end
    end
  end

  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.busy_res   = (cmd_d != CMD_IDLE);
    res_o.read_data  = last_d;
    res_o.read_valid = rvalid;
  end

endmodule

### hdl/i2cbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbb_checker
// Port-level checks of the I2C byte engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbb_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic                        scl_i,
  input logic                        sda_i,
  input logic                        busy_i,
  input logic                        read_valid_i,
  input logic [i2cbb_pkg::ByteW-1:0] read_data_i
);
  import i2cbb_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result item dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(read_data_i) && $stable(scl_i)
                                    && $stable(sda_i) && $stable(busy_i))
    else $error("result item changed while stalled");

  // a full input stage only stalls behind a held result
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> res_valid_i && !res_ready_i)
    else $error("input stalled without output backpressure");

  // a finished read leaves the bus with SCL low, SDA driven low (ack)
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && read_valid_i |-> !busy_i && !scl_i && !sda_i)
    else $error("read completion with wrong bus levels");

endmodule

bind i2c_bitbang_master_top i2cbb_checker u_i2cbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .scl_i        (res_o.scl_out),
  .sda_i        (res_o.sda_out),
  .busy_i       (res_o.busy_res),
  .read_valid_i (res_o.read_valid),
  .read_data_i  (res_o.read_data)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C bit-bang byte engine. Start, stop, write and
// read sequences are fed as command and tick items. A local bus model predicts
// the SCL/SDA levels, the busy flag and the read byte for every accepted item,
// and each result is checked field by field. Phases cover several tick
// settings, including zero and the largest value, under sender gaps, receiver
// stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cbb_pkg::*;

  localparam logic [CmdW-1:0] REQ_TICK      = CMD_IDLE;
  localparam logic [CmdW-1:0] CMD_BAD_FIRST = 3'd5;
  localparam logic [CmdW-1:0] CMD_BAD_LAST  = 3'd7;
  localparam int unsigned     HOLD_CYCLES   = 300;

  logic clk_i;
  logic rst_ni;

  i2cbb_req_if req_if ();
  i2cbb_res_if res_if ();
  i2cbb_cfg_if cfg_if ();

  i2c_bitbang_master_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // bus model state
  logic [TickW-1:0] half_q   = HALF_PERIOD_RST;
  logic [CmdW-1:0]  bus_cmd  = CMD_IDLE;
  logic [StepW-1:0] step_no  = '0;
  logic [TickW-1:0] tick_cnt = '0;
  logic [ByteW-1:0] shreg    = '0;
  logic             scl_lvl  = 1'b1;
  logic             sda_lvl  = 1'b1;
  logic [ByteW-1:0] last_rd  = '0;

  req_t        req_items_q[$];
  res_t        expected_levels_q[$];
  int unsigned items_pushed  = 0;
  int unsigned items_taken   = 0;
  int unsigned res_seen      = 0;
  int unsigned reads_seen    = 0;
  int unsigned settings_done = 0;
  int unsigned err_cnt       = 0;
  int unsigned send_idle     = 0;
  int unsigned recv_stall    = 0;
  bit          hold_rx       = 1'b0;
  bit          req_taken     = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_t advance_bus(req_t it);
    res_t        o;
    int unsigned b;
    bit          second;
    bit          rd_done;
    rd_done = 1'b0;
    if (it.req_type == REQ_TICK) begin
      if (bus_cmd != CMD_IDLE) begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= half_q) begin
          tick_cnt = '0;
          step_no  = step_no + 1'b1;
          b        = (step_no - 1) >> 1;
          second   = !step_no[0];
          case (bus_cmd)
            CMD_START: begin
              if (step_no == 1) sda_lvl = 1'b0;
              else begin
                scl_lvl = 1'b0;
                bus_cmd = CMD_IDLE;
              end
            end
            CMD_STOP: begin
              if (step_no == 1) sda_lvl = 1'b1;
              else bus_cmd = CMD_IDLE;
            end
            CMD_WRITE: begin
              if (!second) scl_lvl = 1'b1;
              else begin
                scl_lvl = 1'b0;
                if (b < 7) sda_lvl = shreg[6-b];
                else bus_cmd = CMD_IDLE;
              end
            end
            CMD_READ: begin
              if (b >= 8) begin
                scl_lvl = 1'b0;
                last_rd = shreg;
                bus_cmd = CMD_IDLE;
                rd_done = 1'b1;
              end else if (!second) begin
                shreg   = {shreg[ByteW-2:0], it.sda_in};
                scl_lvl = 1'b0;
              end else if (b < 7) begin
                scl_lvl = 1'b1;
              end else begin
                sda_lvl = 1'b0;
                scl_lvl = 1'b1;
              end
            end
            default: bus_cmd = CMD_IDLE;
          endcase
          if (bus_cmd == CMD_IDLE) step_no = '0;
        end
      end
    end else if (it.req_type <= CMD_READ && bus_cmd == CMD_IDLE) begin
      bus_cmd  = it.req_type;
      step_no  = '0;
      tick_cnt = '0;
      case (it.req_type)
        CMD_START: begin
          scl_lvl = 1'b1;
          sda_lvl = 1'b1;
        end
        CMD_STOP: begin
          sda_lvl = 1'b0;
          scl_lvl = 1'b1;
        end
        CMD_WRITE: begin
          shreg   = it.write_data;
          sda_lvl = it.write_data[ByteW-1];
        end
        default: begin
          shreg   = '0;
          sda_lvl = 1'b1;
          scl_lvl = 1'b1;
        end
      endcase
    end
    o.scl_out    = scl_lvl;
    o.sda_out    = sda_lvl;
    o.busy_res   = (bus_cmd != CMD_IDLE);
    o.read_data  = last_rd;
    o.read_valid = rd_done;
    return o;
  endfunction

  function automatic int unsigned delay_units(logic [CmdW-1:0] cmd);
    case (cmd)
      CMD_WRITE: return 16;
      CMD_READ:  return 17;
      default:   return 2;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] MISMATCH result %0d %s: got %0h want %0h", $time, res_seen, what,
             got, want);
    err_cnt++;
  endtask

  // sample at rising edge: predict accepted items, check accepted results
  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    req_t it;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        it.req_type   = req_if.req_type;
        it.write_data = req_if.write_data;
        it.sda_in     = req_if.sda_in;
        expected_levels_q.push_back(advance_bus(it));
        items_taken++;
        req_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        got.scl_out    = res_if.scl_out;
        got.sda_out    = res_if.sda_out;
        got.busy_res   = res_if.busy_res;
        got.read_data  = res_if.read_data;
        got.read_valid = res_if.read_valid;
        if (expected_levels_q.size() == 0) begin
          report_mismatch("result with no item pending", 32'(got), 0);
        end else begin
          want = expected_levels_q.pop_front();
          if (got.scl_out !== want.scl_out)
            report_mismatch("scl_out", 32'(got.scl_out), 32'(want.scl_out));
          if (got.sda_out !== want.sda_out)
            report_mismatch("sda_out", 32'(got.sda_out), 32'(want.sda_out));
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
          if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", 32'(got.read_valid), 32'(want.read_valid));
          if (want.read_valid) reads_seen++;
        end
        res_seen++;
      end
      if (cfg_if.valid && cfg_if.ready) half_q = cfg_if.data;
    end
  end

  // drive at falling edge
  always @(negedge clk_i) begin : driver
    req_t it;
    if (!req_if.valid || req_taken) begin
      if (req_items_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        it = req_items_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.req_type   <= it.req_type;
        req_if.write_data <= it.write_data;
        req_if.sda_in     <= it.sda_in;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    res_if.ready <= hold_rx ? 1'b0 : ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic push_item(input logic [CmdW-1:0] t, input logic [ByteW-1:0] wd,
                           input logic s);
    req_t it;
    it.req_type   = t;
    it.write_data = wd;
    it.sda_in     = s;
    req_items_q.push_back(it);
    items_pushed++;
  endtask

  task automatic push_ticks(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) push_item(REQ_TICK, ByteW'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    while (items_taken != items_pushed || expected_levels_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_half_period(input logic [TickW-1:0] hp);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= hp;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    settings_done++;
  endtask

  task automatic run_phase(input logic [TickW-1:0] hp, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_items,
                           input bit squeeze);
    int unsigned     unit;
    int unsigned     cnt;
    int unsigned     nt;
    int unsigned     sel;
    int unsigned     i;
    logic [CmdW-1:0] cmd;
    logic [CmdW-1:0] noise;
    wait_drained();
    set_half_period(hp);
    @(posedge clk_i);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    unit       = (hp == 0) ? 1 : hp;
    cnt        = 0;
    while (cnt < n_items) begin
      sel = $urandom_range(0, 99);
      cmd = CmdW'($urandom_range(CMD_START, CMD_READ));
      nt  = delay_units(cmd) * unit;
      if (sel < 80) begin
        push_item(cmd, ByteW'($urandom), 1'($urandom));
        for (i = 0; i < nt; i++) begin
          // stray command while busy
          if ($urandom_range(0, 19) == 0)
            push_item(CmdW'($urandom_range(CMD_START, CMD_BAD_LAST)), ByteW'($urandom),
                      1'($urandom));
          push_item(REQ_TICK, ByteW'($urandom), 1'($urandom));
        end
        cnt += nt + 1;
      end else if (sel < 90) begin
        noise = $urandom_range(0, 1) ? REQ_TICK
                                     : CmdW'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        push_item(noise, ByteW'($urandom), 1'($urandom));
      end else begin
        // cut-short sequence
        push_item(cmd, ByteW'($urandom), 1'($urandom));
        nt = $urandom_range(0, nt - 1);
        push_ticks(nt);
        cnt += nt + 1;
      end
    end
    push_ticks(delay_units(CMD_READ) * unit + 2);
    if (squeeze) begin
      fork
        begin
          hold_rx = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_rx = 1'b0;
        end
      join_none
    end
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_TICK;
    req_if.write_data = '0;
    req_if.sda_in     = 1'b0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero tick setting, each delay ends on one tick
    set_half_period('0);
    @(posedge clk_i);
    push_item(REQ_TICK, 8'h00, 1'b1);
    push_item(CMD_BAD_FIRST, 8'hFF, 1'b1);
    push_item(CmdW'(CMD_BAD_FIRST + 1), 8'h00, 1'b0);
    push_item(CMD_BAD_LAST, 8'hFF, 1'b1);
    push_item(CMD_START, 8'h00, 1'b0);
    push_item(REQ_TICK, 8'h00, 1'b1);
    push_item(CMD_READ, 8'hFF, 1'b1);
    push_item(REQ_TICK, 8'h00, 1'b0);
    push_item(CMD_STOP, 8'h00, 1'b0);
    push_ticks(2);
    push_item(CMD_WRITE, 8'hFF, 1'b0);
    push_ticks(delay_units(CMD_WRITE));
    push_item(CMD_READ, 8'h00, 1'b1);
    push_ticks(delay_units(CMD_READ) + 2);

    run_phase(16'd1, 0, 0, 40, 1'b1);
    run_phase(16'd4, 63, 0, 40, 1'b0);
    run_phase(16'd2, 0, 63, 40, 1'b0);
    run_phase(16'd0, 8, 8, 40, 1'b0);

    // largest tick setting: a start left running, a write ignored while busy
    wait_drained();
    set_half_period(16'hFFFF);
    @(posedge clk_i);
    send_idle  = 0;
    recv_stall = 0;
    push_item(CMD_START, ByteW'($urandom), 1'($urandom));
    push_ticks(20);
    push_item(CMD_WRITE, ByteW'($urandom), 1'($urandom));
    push_ticks(20);

    wait_drained();
    repeat (6) @(posedge clk_i);
    $display("Summary: %0d items and %0d results over %0d tick settings, %0d reads done",
             items_taken, res_seen, settings_done, reads_seen);
    $display("Summary: %0d mismatches reported", err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timeout after %0d of %0d items", items_taken, items_pushed);
    $display("Verification failed");
    $finish;
  end

endmodule
